// ===== sv/lmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared widths, codes, types and log2 helpers for the log min/max axis scaler.
// ----------------------------------------------------------------------------
package lmm_pkg;

   localparam int VALUE_W   = 64;
   localparam int OUT_W     = 32;
   localparam int FRAC_W    = 24;
   localparam int IDX_W     = $clog2(VALUE_W);
   localparam int EXP_W     = IDX_W + 1;
   localparam int LOG_W     = EXP_W + FRAC_W;
   localparam int MANT_W    = 32;
   localparam int RF_W      = 16;
   localparam int OMR_W     = RF_W + 1;
   localparam int A_W       = LOG_W + OMR_W;
   localparam int N_W       = A_W + OUT_W;
   localparam int D_W       = LOG_W + RF_W;
   localparam int REM_W     = D_W + 1;
   localparam int CNT_W     = $clog2(FRAC_W);
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN     = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_INVALID_EN    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_RESERVED_FRAC = 2'd3;

   localparam logic [OUT_W-1:0] FULL_SCALE = '1;
   localparam logic [OUT_W-1:0] MID_SCALE  = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [LOG_W-1:0] LOG_TOP    = LOG_W'(VALUE_W) << FRAC_W;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SETUP,
      CS_TOP,
      CS_NORM,
      CS_SQ,
      CS_STORE,
      CS_FIN
   } cfg_state_type;

   // config values plus everything derived from them
   typedef struct packed {
      logic [VALUE_W-1:0] mn;
      logic               nonpos;
      logic               degen;
      logic               inv_en;
      logic [OMR_W-1:0]   omr;
      logic [OUT_W-1:0]   band;
      logic [OUT_W-1:0]   limit;
      logic [LOG_W-1:0]   lmin;
      logic [LOG_W-1:0]   den;
      logic               den_zero;
   } cfg_type;

   typedef struct packed {
      logic             vld;
      logic             kill;
      logic             nz;
      logic [LOG_W-1:0] num;
   } num_type;

   typedef struct packed {
      logic             vld;
      logic [OUT_W-1:0] word;
   } res_type;

   typedef struct packed {
      logic              fbit;
      logic [MANT_W-1:0] m;
   } sq_type;

   // index of the top set bit
   function automatic logic [IDX_W-1:0] f_top_idx(input logic [VALUE_W-1:0] x);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (x[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // mantissa in Q1.31, truncated
   function automatic logic [MANT_W-1:0] f_norm(input logic [VALUE_W-1:0] x,
                                                input logic [IDX_W-1:0]   e);
      logic [VALUE_W-1:0] t;
      if (e >= IDX_W'(MANT_W-1)) begin
         t = x >> (e - IDX_W'(MANT_W-1));
      end else begin
         t = x << (IDX_W'(MANT_W-1) - e);
      end
      return t[MANT_W-1:0];
   endfunction

   // one squaring step: square, rescale, renormalize
   function automatic sq_type f_sq(input logic [MANT_W-1:0] m);
      logic [2*MANT_W-1:0] p;
      logic [MANT_W:0]     t;
      sq_type              r;
      p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
      t = p[2*MANT_W-1:MANT_W-1];
      r.fbit = t[MANT_W];
      r.m    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      return r;
   endfunction

endpackage

// ===== sv/lmm_chan_if.sv =====
// ----------------------------------------------------------------------------
// lmm_chan_if
// Valid/ready channels: request words in, response words out.
// ----------------------------------------------------------------------------
interface lmm_req_if;
   logic                       valid;
   logic                       ready;
   logic [lmm_pkg::VALUE_W-1:0] sample_value;
   logic                       is_invalid;

   modport source (output valid, output sample_value, output is_invalid, input ready);
   modport sink   (input valid, input sample_value, input is_invalid, output ready);
endinterface

interface lmm_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [lmm_pkg::OUT_W-1:0] plot_position;

   modport source (output valid, output plot_position, input ready);
   modport sink   (input valid, input plot_position, output ready);
endinterface

// ===== sv/lmm_cfg.sv =====
// ----------------------------------------------------------------------------
// lmm_cfg
// Config registers and a sequencer that derives log bounds, span and band.
// ----------------------------------------------------------------------------
module lmm_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lmm_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [lmm_pkg::VALUE_W-1:0]     csr_wdata,
   output lmm_pkg::cfg_type                cfg,
   output logic                            busy
);

   lmm_pkg::cfg_state_type state_ff, state_in;

   logic [lmm_pkg::VALUE_W-1:0] mn_ff, mx_ff;
   logic                        ip_ff;
   logic [lmm_pkg::RF_W-1:0]    rf_ff;

   logic [lmm_pkg::VALUE_W:0]   x_ff, x_in;
   logic [lmm_pkg::IDX_W-1:0]   e_ff, e_in;
   logic                        big_ff, big_in;
   logic [lmm_pkg::MANT_W-1:0]  m_ff, m_in;
   logic [lmm_pkg::FRAC_W-1:0]  frac_ff, frac_in;
   logic [lmm_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        side_ff, side_in;
   logic [lmm_pkg::LOG_W-1:0]   lmax_ff, lmax_in;

   logic                        nonpos_ff, nonpos_in;
   logic                        degen_ff, degen_in;
   logic [lmm_pkg::OMR_W-1:0]   omr_ff, omr_in;
   logic [lmm_pkg::OUT_W-1:0]   band_ff, band_in;
   logic [lmm_pkg::OUT_W-1:0]   limit_ff, limit_in;
   logic [lmm_pkg::LOG_W-1:0]   lmin_ff, lmin_in;
   logic [lmm_pkg::LOG_W-1:0]   den_ff, den_in;
   logic                        den_zero_ff, den_zero_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmm_pkg::CS_SETUP;
         mn_ff    <= '0;
         mx_ff    <= '0;
         ip_ff    <= 1'b0;
         rf_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               lmm_pkg::REG_RANGE_MIN:     mn_ff <= csr_wdata;
               lmm_pkg::REG_RANGE_MAX:     mx_ff <= csr_wdata;
               lmm_pkg::REG_INVALID_EN:    ip_ff <= csr_wdata[0];
               lmm_pkg::REG_RESERVED_FRAC: rf_ff <= csr_wdata[lmm_pkg::RF_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      e_ff        <= e_in;
      big_ff      <= big_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      cnt_ff      <= cnt_in;
      side_ff     <= side_in;
      lmax_ff     <= lmax_in;
      nonpos_ff   <= nonpos_in;
      degen_ff    <= degen_in;
      omr_ff      <= omr_in;
      band_ff     <= band_in;
      limit_ff    <= limit_in;
      lmin_ff     <= lmin_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
   end

   always_comb begin
      logic [lmm_pkg::RF_W-1:0]          r;
      logic [lmm_pkg::RF_W+lmm_pkg::OUT_W-1:0] fr;
      logic [lmm_pkg::LOG_W-1:0]         l;
      logic [lmm_pkg::LOG_W-1:0]         d;
      lmm_pkg::sq_type                   sq;

      state_in    = state_ff;
      x_in        = x_ff;
      e_in        = e_ff;
      big_in      = big_ff;
      m_in        = m_ff;
      frac_in     = frac_ff;
      cnt_in      = cnt_ff;
      side_in     = side_ff;
      lmax_in     = lmax_ff;
      nonpos_in   = nonpos_ff;
      degen_in    = degen_ff;
      omr_in      = omr_ff;
      band_in     = band_ff;
      limit_in    = limit_ff;
      lmin_in     = lmin_ff;
      den_in      = den_ff;
      den_zero_in = den_zero_ff;
      r  = ip_ff ? rf_ff : '0;
      fr = {r, lmm_pkg::OUT_W'(0)} - (lmm_pkg::RF_W + lmm_pkg::OUT_W)'(r);
      l  = big_ff ? lmm_pkg::LOG_TOP : {1'b0, e_ff, frac_ff};
      d  = lmax_ff - lmin_ff;
      sq = lmm_pkg::f_sq(m_ff);

      case (state_ff)
         lmm_pkg::CS_IDLE: ;
         lmm_pkg::CS_SETUP: begin
            nonpos_in = mn_ff[lmm_pkg::VALUE_W-1] | (mn_ff == '0);
            degen_in  = (mn_ff == mx_ff) | ($signed(mx_ff) < $signed(mn_ff));
            omr_in    = (lmm_pkg::OMR_W'(1) << lmm_pkg::RF_W) - lmm_pkg::OMR_W'(r);
            band_in   = fr[lmm_pkg::RF_W+lmm_pkg::OUT_W-1:lmm_pkg::RF_W];
            // shifted upper bound: max - min + 1, may reach 2^64
            x_in      = nonpos_in ? ({1'b0, mx_ff - mn_ff} + (lmm_pkg::VALUE_W+1)'(1))
                                  : {1'b0, mx_ff};
            side_in   = 1'b0;
            state_in  = lmm_pkg::CS_TOP;
         end
         lmm_pkg::CS_TOP: begin
            e_in     = lmm_pkg::f_top_idx(x_ff[lmm_pkg::VALUE_W-1:0]);
            big_in   = x_ff[lmm_pkg::VALUE_W];
            state_in = lmm_pkg::CS_NORM;
         end
         lmm_pkg::CS_NORM: begin
            m_in     = lmm_pkg::f_norm(x_ff[lmm_pkg::VALUE_W-1:0], e_ff);
            frac_in  = '0;
            cnt_in   = '0;
            state_in = lmm_pkg::CS_SQ;
         end
         lmm_pkg::CS_SQ: begin
            m_in    = sq.m;
            frac_in = {frac_ff[lmm_pkg::FRAC_W-2:0], sq.fbit};
            cnt_in  = cnt_ff + lmm_pkg::CNT_W'(1);
            if (cnt_ff == lmm_pkg::CNT_W'(lmm_pkg::FRAC_W-1)) begin
               state_in = lmm_pkg::CS_STORE;
            end
         end
         lmm_pkg::CS_STORE: begin
            if (!side_ff) begin
               lmax_in  = l;
               // shifted lower bound is 1, whose log is 0
               x_in     = nonpos_ff ? (lmm_pkg::VALUE_W+1)'(1) : {1'b0, mn_ff};
               side_in  = 1'b1;
               state_in = lmm_pkg::CS_TOP;
            end else begin
               lmin_in  = l;
               state_in = lmm_pkg::CS_FIN;
            end
         end
         lmm_pkg::CS_FIN: begin
            den_in      = d;
            den_zero_in = (d == '0);
            limit_in    = lmm_pkg::FULL_SCALE - band_ff;
            state_in    = lmm_pkg::CS_IDLE;
         end
         default: state_in = lmm_pkg::CS_SETUP;
      endcase

      if (csr_we) begin
         state_in = lmm_pkg::CS_SETUP;
      end
   end

   assign busy         = (state_ff != lmm_pkg::CS_IDLE);
   assign cfg.mn       = mn_ff;
   assign cfg.nonpos   = nonpos_ff;
   assign cfg.degen    = degen_ff;
   assign cfg.inv_en   = ip_ff;
   assign cfg.omr      = omr_ff;
   assign cfg.band     = band_ff;
   assign cfg.limit    = limit_ff;
   assign cfg.lmin     = lmin_ff;
   assign cfg.den      = den_ff;
   assign cfg.den_zero = den_zero_ff;

endmodule

// ===== sv/lmm_log_pipe.sv =====
// ----------------------------------------------------------------------------
// lmm_log_pipe
// Clamp, shift, normalize and one squaring stage per fraction bit of log2.
// ----------------------------------------------------------------------------
module lmm_log_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [lmm_pkg::VALUE_W-1:0] sample_value,
   input  logic                        is_invalid,
   input  lmm_pkg::cfg_type            cfg,
   output lmm_pkg::num_type            num_o
);

   typedef struct packed {
      logic                        vld;
      logic                        kill;
      logic [lmm_pkg::VALUE_W-1:0] vc;
   } clamp_type;

   typedef struct packed {
      logic                        vld;
      logic                        kill;
      logic [lmm_pkg::VALUE_W:0]   x;
   } shift_type;

   typedef struct packed {
      logic                        vld;
      logic                        kill;
      logic                        big;
      logic [lmm_pkg::IDX_W-1:0]   e;
      logic [lmm_pkg::VALUE_W-1:0] x;
   } top_type;

   typedef struct packed {
      logic                        vld;
      logic                        kill;
      logic                        big;
      logic [lmm_pkg::IDX_W-1:0]   e;
      logic [lmm_pkg::MANT_W-1:0]  m;
      logic [lmm_pkg::FRAC_W-1:0]  frac;
   } sq_stage_type;

   clamp_type        cl_ff, cl_in;
   shift_type        sh_ff, sh_in;
   top_type          tp_ff, tp_in;
   sq_stage_type     sq_ff [lmm_pkg::FRAC_W+1];
   sq_stage_type     sq_in [lmm_pkg::FRAC_W+1];
   lmm_pkg::num_type num_ff, num_in;

   always_comb begin
      logic [lmm_pkg::LOG_W-1:0] lv;
      lmm_pkg::sq_type           sq;

      // values below the lower bound clamp to it
      cl_in.vld  = in_vld;
      cl_in.kill = cfg.inv_en & is_invalid;
      cl_in.vc   = ($signed(sample_value) < $signed(cfg.mn)) ? cfg.mn : sample_value;

      sh_in.vld  = cl_ff.vld;
      sh_in.kill = cl_ff.kill;
      sh_in.x    = cfg.nonpos
                   ? ({1'b0, cl_ff.vc - cfg.mn} + (lmm_pkg::VALUE_W+1)'(1))
                   : {1'b0, cl_ff.vc};

      tp_in.vld  = sh_ff.vld;
      tp_in.kill = sh_ff.kill;
      tp_in.big  = sh_ff.x[lmm_pkg::VALUE_W];
      tp_in.x    = sh_ff.x[lmm_pkg::VALUE_W-1:0];
      tp_in.e    = lmm_pkg::f_top_idx(sh_ff.x[lmm_pkg::VALUE_W-1:0]);

      sq_in[0].vld  = tp_ff.vld;
      sq_in[0].kill = tp_ff.kill;
      sq_in[0].big  = tp_ff.big;
      sq_in[0].e    = tp_ff.e;
      sq_in[0].m    = lmm_pkg::f_norm(tp_ff.x, tp_ff.e);
      sq_in[0].frac = '0;

      for (int k = 0; k < lmm_pkg::FRAC_W; k++) begin
         sq             = lmm_pkg::f_sq(sq_ff[k].m);
         sq_in[k+1]      = sq_ff[k];
         sq_in[k+1].m    = sq.m;
         sq_in[k+1].frac = {sq_ff[k].frac[lmm_pkg::FRAC_W-2:0], sq.fbit};
      end

      lv = sq_ff[lmm_pkg::FRAC_W].big ? lmm_pkg::LOG_TOP
           : {1'b0, sq_ff[lmm_pkg::FRAC_W].e, sq_ff[lmm_pkg::FRAC_W].frac};
      num_in.vld  = sq_ff[lmm_pkg::FRAC_W].vld;
      num_in.kill = sq_ff[lmm_pkg::FRAC_W].kill;
      num_in.num  = lv - cfg.lmin;
      num_in.nz   = (lv == cfg.lmin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_ff.vld  <= 1'b0;
         sh_ff.vld  <= 1'b0;
         tp_ff.vld  <= 1'b0;
         num_ff.vld <= 1'b0;
         for (int k = 0; k <= lmm_pkg::FRAC_W; k++) begin
            sq_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         cl_ff  <= cl_in;
         sh_ff  <= sh_in;
         tp_ff  <= tp_in;
         num_ff <= num_in;
         for (int k = 0; k <= lmm_pkg::FRAC_W; k++) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   assign num_o = num_ff;

endmodule

// ===== sv/lmm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// lmm_div_pipe
// Scale the log offset, divide by the log span one quotient bit per stage,
// add the band, saturate and invert.
// ----------------------------------------------------------------------------
module lmm_div_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  lmm_pkg::num_type num_i,
   input  lmm_pkg::cfg_type cfg,
   output lmm_pkg::res_type res_o
);

   typedef struct packed {
      logic                    vld;
      logic                    kill;
      logic                    nz;
      logic [lmm_pkg::A_W-1:0] a;
   } a_stage_type;

   typedef struct packed {
      logic                    vld;
      logic                    kill;
      logic                    nz;
      logic [lmm_pkg::N_W-1:0] n;
   } n_stage_type;

   typedef struct packed {
      logic                      vld;
      logic                      kill;
      logic                      nz;
      logic                      ovf;
      logic [lmm_pkg::REM_W-1:0] rem;
      logic [lmm_pkg::OUT_W-1:0] lq;
   } dv_stage_type;

   typedef struct packed {
      logic                      vld;
      logic                      kill;
      logic [lmm_pkg::OUT_W-1:0] pos;
   } pos_stage_type;

   a_stage_type      a_ff, a_in;
   n_stage_type      n_ff, n_in;
   dv_stage_type     dv_ff [lmm_pkg::OUT_W+1];
   dv_stage_type     dv_in [lmm_pkg::OUT_W+1];
   pos_stage_type    ps_ff, ps_in;
   lmm_pkg::res_type res_ff, res_in;

   logic [lmm_pkg::REM_W-1:0] dvsr;

   // divisor is the log span in Q.16
   assign dvsr = {1'b0, cfg.den, lmm_pkg::RF_W'(0)};

   always_comb begin
      logic [lmm_pkg::REM_W-1:0] rem2;
      logic                      ge;
      logic [lmm_pkg::OUT_W-1:0] q;

      a_in.vld  = num_i.vld;
      a_in.kill = num_i.kill;
      a_in.nz   = num_i.nz;
      a_in.a    = {{lmm_pkg::OMR_W{1'b0}}, num_i.num} * {{lmm_pkg::LOG_W{1'b0}}, cfg.omr};

      // a * (2^OUT_W - 1) as a shift and subtract
      n_in.vld  = a_ff.vld;
      n_in.kill = a_ff.kill;
      n_in.nz   = a_ff.nz;
      n_in.n    = {a_ff.a, lmm_pkg::OUT_W'(0)} - lmm_pkg::N_W'(a_ff.a);

      dv_in[0].vld  = n_ff.vld;
      dv_in[0].kill = n_ff.kill;
      dv_in[0].nz   = n_ff.nz;
      dv_in[0].rem  = n_ff.n[lmm_pkg::N_W-1:lmm_pkg::OUT_W];
      dv_in[0].lq   = n_ff.n[lmm_pkg::OUT_W-1:0];
      // quotient needs more than OUT_W bits: saturates
      dv_in[0].ovf  = (n_ff.n[lmm_pkg::N_W-1:lmm_pkg::OUT_W] >= dvsr);

      for (int k = 0; k < lmm_pkg::OUT_W; k++) begin
         rem2 = {dv_ff[k].rem[lmm_pkg::REM_W-2:0], dv_ff[k].lq[lmm_pkg::OUT_W-1]};
         ge   = (rem2 >= dvsr);
         dv_in[k+1]     = dv_ff[k];
         dv_in[k+1].rem = ge ? (rem2 - dvsr) : rem2;
         dv_in[k+1].lq  = {dv_ff[k].lq[lmm_pkg::OUT_W-2:0], ge};
      end

      q = dv_ff[lmm_pkg::OUT_W].lq;
      ps_in.vld  = dv_ff[lmm_pkg::OUT_W].vld;
      ps_in.kill = dv_ff[lmm_pkg::OUT_W].kill;
      if (cfg.den_zero) begin
         ps_in.pos = dv_ff[lmm_pkg::OUT_W].nz ? cfg.band : lmm_pkg::FULL_SCALE;
      end else if (dv_ff[lmm_pkg::OUT_W].ovf || (q > cfg.limit)) begin
         ps_in.pos = lmm_pkg::FULL_SCALE;
      end else begin
         ps_in.pos = q + cfg.band;
      end

      res_in.vld = ps_ff.vld;
      if (ps_ff.kill) begin
         res_in.word = lmm_pkg::FULL_SCALE;
      end else if (cfg.degen) begin
         res_in.word = lmm_pkg::MID_SCALE;
      end else begin
         res_in.word = ~ps_ff.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld   <= 1'b0;
         n_ff.vld   <= 1'b0;
         ps_ff.vld  <= 1'b0;
         res_ff.vld <= 1'b0;
         for (int k = 0; k <= lmm_pkg::OUT_W; k++) begin
            dv_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         a_ff   <= a_in;
         n_ff   <= n_in;
         ps_ff  <= ps_in;
         res_ff <= res_in;
         for (int k = 0; k <= lmm_pkg::OUT_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   assign res_o = res_ff;

endmodule

// ===== sv/log_minmax_axis_scaler.sv =====
// ----------------------------------------------------------------------------
// log_minmax_axis_scaler
// Places signed 64-bit column values on an inverted 32-bit log-scale axis.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word contents
//  req_chan  in   valid / ready    sample_value[63:0], is_invalid
//  rsp_chan  out  valid / ready    plot_position[31:0]
//  csr_*     in   csr_we only      csr_index[1:0], csr_wdata[63:0]
//
//  One word per cycle while the output word is not held; 66 register stages, among
//  them the squaring stages of log2 and the restoring divide stages.
//  Synchronous reset; after reset and after every csr write a sequencer
//  derives log bounds, span and band, req_chan.ready low meanwhile.
//  A stalled output word freezes the whole pipe; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module log_minmax_axis_scaler (
   input  logic                          clock,
   input  logic                          reset,
   lmm_req_if.sink                       req_chan,
   lmm_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [lmm_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [lmm_pkg::VALUE_W-1:0]   csr_wdata
);

   lmm_pkg::cfg_type cfg;
   lmm_pkg::num_type num;
   lmm_pkg::res_type res;
   logic             busy;
   logic             en;
   logic             accept;

   // config registers and derived constants
   lmm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (busy)
   );

   // whole pipe moves unless the output word is held
   assign en     = !res.vld || rsp_chan.ready;
   assign req_chan.ready = en && !busy;
   assign accept = req_chan.valid && req_chan.ready;

   // clamp, shift and fixed-point log2
   lmm_log_pipe u_log (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_vld       (accept),
      .sample_value (req_chan.sample_value),
      .is_invalid   (req_chan.is_invalid),
      .cfg          (cfg),
      .num_o        (num)
   );

   // ratio, band, saturation and inversion; last stage is the output register
   lmm_div_pipe u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .num_i (num),
      .cfg   (cfg),
      .res_o (res)
   );

   assign rsp_chan.valid         = res.vld;
   assign rsp_chan.plot_position = res.word;

endmodule

// ===== dv/log_minmax_axis_scaler_test.sv =====
// ----------------------------------------------------------------------------
// log_minmax_axis_scaler_test
// Self-checking bench: drives sample words under several axis settings and
// compares every plot position against an in-bench log2 / divide predictor.
// ----------------------------------------------------------------------------
module log_minmax_axis_scaler_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 100;       // pipe is 66 deep

   logic clock;
   logic reset;
   logic csr_we;
   logic [lmm_pkg::REG_IDX_W-1:0] csr_index;
   logic [lmm_pkg::VALUE_W-1:0] csr_wdata;

   lmm_req_if req_chan ();
   lmm_rsp_if rsp_chan ();

   log_minmax_axis_scaler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the axis settings
   logic [63:0] axis_min, axis_max;
   logic        inv_en;
   logic [15:0] rsv_frac;

   logic [lmm_pkg::OUT_W-1:0] plot_expected[$];
   int   mismatches;
   int   cycles;
   bit   no_idle;   // long stretch with neither side idling

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("log_minmax_axis_scaler: mismatch");
         $finish;
      end
   end

   // log2 with 24 fraction bits: top bit index, then repeated squaring of the
   // Q1.31 mantissa, one fraction bit per square
   function automatic logic [63:0] log2_q24(input logic [63:0] x);
      int e;
      logic [63:0] m;
      logic [23:0] fr;
      if (x == 0) return 64'd0;
      e = 0;
      for (int i = 0; i < 64; i++) if (x[i]) e = i;
      m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
      fr = '0;
      for (int i = 0; i < lmm_pkg::FRAC_W; i++) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            fr = {fr[22:0], 1'b1};
            m = m >> 1;
         end else begin
            fr = {fr[22:0], 1'b0};
         end
      end
      return (64'(e) << lmm_pkg::FRAC_W) | 64'(fr);
   endfunction

   // log of (u + 1) where u + 1 may reach 2^64
   function automatic logic [63:0] log2_plus1(input logic [63:0] u);
      if (u == '1) return 64'd64 << lmm_pkg::FRAC_W;
      return log2_q24(u + 64'd1);
   endfunction

   function automatic logic [lmm_pkg::OUT_W-1:0] plot_position_of(input logic [63:0] sv_in,
                                                                  input logic inv);
      logic [63:0]  v, lmin, lmax, lv, num, den, band, full, r;
      logic [127:0] prod, q;
      full = 64'(lmm_pkg::FULL_SCALE);
      if (inv_en && inv) return lmm_pkg::FULL_SCALE;
      if (axis_min == axis_max || $signed(axis_max) < $signed(axis_min))
         return lmm_pkg::MID_SCALE;
      v = ($signed(sv_in) < $signed(axis_min)) ? axis_min : sv_in;
      if (axis_min[63] || axis_min == 0) begin
         // non-positive minimum: shift so the lower bound becomes one
         lmin = 0;
         lmax = log2_plus1(axis_max - axis_min);
         lv   = log2_plus1(v - axis_min);
      end else begin
         lmin = log2_q24(axis_min);
         lmax = log2_q24(axis_max);
         lv   = log2_q24(v);
      end
      r    = inv_en ? 64'(rsv_frac) : 64'd0;
      band = (full * r) >> 16;
      num  = lv - lmin;
      den  = lmax - lmin;
      if (den == 0) begin
         // span quantized away
         return ~((num == 0) ? band[lmm_pkg::OUT_W-1:0] : lmm_pkg::FULL_SCALE);
      end
      prod = 128'(num * (64'd65536 - r)) * 128'(full);
      q    = prod / 128'(den << 16);
      if (q > 128'(full - band)) return ~lmm_pkg::FULL_SCALE;
      return ~(q[lmm_pkg::OUT_W-1:0] + band[lmm_pkg::OUT_W-1:0]);
   endfunction

   // response checker with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (plot_expected.size() == 0) begin
               $error("plot_position: none expected, actual %h", rsp_chan.plot_position);
               mismatches++;
            end else begin
               if (rsp_chan.plot_position !== plot_expected[0]) begin
                  $error("plot_position: expected %h, actual %h",
                         plot_expected[0], rsp_chan.plot_position);
                  mismatches++;
               end
               void'(plot_expected.pop_front());
            end
         end
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 24);
      end
   end

   // one sample word; valid stays high unless a gap is drawn
   task automatic send_sample(input logic [63:0] value, input logic inv);
      req_chan.valid        <= 1'b1;
      req_chan.sample_value <= value;
      req_chan.is_invalid   <= inv;
      do @(posedge clock); while (!req_chan.ready);
      plot_expected.push_back(plot_position_of(value, inv));
      if (!no_idle && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every expected word is back
   task automatic drain;
      req_chan.valid <= 1'b0;
      while (plot_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // all four registers, written back to back once the pipe has drained
   task automatic set_axis(input logic [63:0] mn, input logic [63:0] mx,
                           input logic ie, input logic [15:0] rf);
      drain();
      csr_we <= 1'b1; csr_index <= lmm_pkg::REG_RANGE_MIN; csr_wdata <= mn;
      @(posedge clock);
      csr_index <= lmm_pkg::REG_RANGE_MAX; csr_wdata <= mx;
      @(posedge clock);
      csr_index <= lmm_pkg::REG_INVALID_EN; csr_wdata <= 64'(ie);
      @(posedge clock);
      csr_index <= lmm_pkg::REG_RESERVED_FRAC; csr_wdata <= 64'(rf);
      @(posedge clock);
      csr_we <= 1'b0;
      axis_min = mn; axis_max = mx; inv_en = ie; rsv_frac = rf;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly inside the range, some at or just outside the bounds, some anywhere
   function automatic logic [63:0] pick_sample();
      logic [64:0] span;
      int k;
      k = $urandom_range(99);
      if (k < 60 && $signed(axis_max) > $signed(axis_min)) begin
         span = 65'(axis_max - axis_min) + 65'd1;
         return axis_min + 64'({1'b0, rand64()} % span);
      end
      if (k < 70) return axis_min;
      if (k < 80) return axis_max;
      if (k < 85) return axis_min - 64'd1;
      if (k < 90) return axis_max + 64'd1;
      return rand64();
   endfunction

   // reset settings: equal bounds give mid scale; is_invalid ignored
   task automatic test_equal_bounds;
      send_sample(64'h8000_0000_0000_0000, 1'b0);
      send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      set_axis(64'd500, 64'd20, 1'b0, 16'h0);     // maximum below minimum
      send_sample(64'd100, 1'b0);
   endtask

   task automatic test_invalid_band;
      set_axis(64'd1, 64'd1000, 1'b1, 16'hFFFF);
      send_sample(64'd10, 1'b1);                  // invalid wins
      send_sample(64'd1, 1'b0);                   // at minimum: band only
      send_sample(64'd1000, 1'b0);
      set_axis(64'd1, 64'd1000, 1'b0, 16'h8000);  // band off
      send_sample(64'd10, 1'b1);
      send_sample(64'd0, 1'b0);                   // below minimum clamps
      send_sample(64'd5000, 1'b0);                // above maximum saturates
   endtask

   task automatic test_full_span;
      set_axis(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 16'h0001);
      send_sample(64'h8000_0000_0000_0000, 1'b0);
      send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_sample(64'd0, 1'b0);
      send_sample(64'hAAAA_5555_AAAA_5555, 1'b0);
   endtask

   task automatic test_flat_log;
      // adjacent large positive bounds: log span quantizes to zero
      set_axis(64'h4000_0000_0000_0000, 64'h4000_0000_0000_0001, 1'b1, 16'h1234);
      send_sample(64'h4000_0000_0000_0000, 1'b0);
      send_sample(64'h4000_0000_0000_0001, 1'b0);
      send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      set_axis(64'd0, 64'd1, 1'b0, 16'hFFFF);     // zero minimum shifts
      send_sample(64'd0, 1'b0);
      send_sample(64'd1, 1'b0);
   endtask

   task automatic test_random_axes;
      logic [63:0] a, b;
      int mode;
      for (int ph = 0; ph < 24; ph++) begin
         mode = $urandom_range(4);
         case (mode)
            0: begin a = rand64(); b = rand64(); end
            1: begin
               a = 64'($urandom_range(1, 1000));
               b = a + 64'($urandom_range(0, 100000));
            end
            2: begin
               a = -64'($urandom_range(0, 5000));
               b = 64'($urandom_range(0, 5000));
            end
            3: begin
               a = rand64() >> 1;
               b = a + 64'($urandom >> $urandom_range(31));
            end
            default: begin
               a = 64'h8000_0000_0000_0000 + 64'($urandom_range(2));
               b = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(2));
            end
         endcase
         if ($urandom_range(9) != 0 && $signed(b) < $signed(a)) begin
            {a, b} = {b, a};
         end
         set_axis(a, b, 1'($urandom_range(1)), 16'($urandom));
         no_idle = (ph == 5);
         for (int n = 0; n < 80; n++) begin
            send_sample(pick_sample(), $urandom_range(99) < 15);
            if (ph == 10 && n == 40) drain();     // hold off until all is back
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      mismatches = 0;
      no_idle    = 1'b0;
      axis_min = '0; axis_max = '0; inv_en = 1'b0; rsv_frac = '0;
      reset <= 1'b1;
      csr_we <= 1'b0; csr_index <= lmm_pkg::REG_RANGE_MIN; csr_wdata <= '0;
      req_chan.valid <= 1'b0; req_chan.sample_value <= '0; req_chan.is_invalid <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_equal_bounds();
      test_invalid_band();
      test_full_span();
      test_flat_log();
      test_random_axes();
      drain();

      if (mismatches == 0) begin
         $display("log_minmax_axis_scaler: match");
      end else begin
         $display("log_minmax_axis_scaler: mismatch");
      end
      $finish;
   end

endmodule
